[hw/rtl/hcdf_pkg.sv]
package hcdf_pkg;

    localparam int LINE_BYTES  = 64;
    localparam int POS_W       = $clog2(LINE_BYTES);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int HEX_W       = 48;

    localparam logic [7:0] CH_SEMI  = 8'h3b;
    localparam logic [7:0] CH_NL    = 8'h0a;
    localparam logic [7:0] CH_COLON = 8'h3a;

    localparam logic [3:0] SLOT_SEMI  = 4'd0;
    localparam logic [3:0] SLOT_NL    = 4'd5;
    localparam logic [3:0] SLOT_COLON = 4'd14;
    localparam logic [3:0] SLOT_BYTE  = 4'd15;

    localparam logic [7:0] HEX_DIGITS [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
    };

    typedef struct packed {
        logic [7:0]  data;
        logic        hdr;
        logic [15:0] csum;
        logic [31:0] addr;
    } t_cmd;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        return HEX_DIGITS[nib];
    endfunction

endpackage

[hw/rtl/hcdf_if.sv]
interface hcdf_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface hcdf_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last_of_run;

    modport source (output valid, output out_char, output last_of_run, input ready);
    modport sink   (input valid, input out_char, input last_of_run, output ready);
endinterface

interface hcdf_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] start_address;

    modport source (output valid, output start_address, input ready);
    modport sink   (input valid, input start_address, output ready);
endinterface

[hw/rtl/checksummed_hex_dump_framer.sv]
// Checksummed hex dump framer.
// i_in carries one raw memory byte per request (data_byte); o_out carries one
// character per request (out_char) with last_of_run set on the raw byte that
// closes each input's run. i_cfg writes start_address: the address counter
// loads it and the checksum and line position clear, starting a new dump.
// Every LINE_BYTES bytes, and for the first byte, a 15-character header
// (';', four hex digits of checksum, newline, eight hex digits of address,
// ':') precedes the byte, so a byte causes 16 or 1 characters.
// The first character of a byte reaches o_out through the queue entry, the
// emitter's index register and the output register. The character emitter
// sends one character per cycle while the receiver is ready.
// A two-entry command queue sits between the byte acceptor and the emitter,
// so i_in takes a new byte each cycle while the queue has room.
// When the receiver stalls, the output register holds its character and the
// queue fills, then i_in.ready drops. Reset clears the checksum, position,
// address (to zero), queue and output valid; i_cfg.ready is always high.
module checksummed_hex_dump_framer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hcdf_cfg_if.sink    i_cfg,
    hcdf_byte_if.sink   i_in,
    hcdf_char_if.source o_out
);

    logic           q_ready;
    logic           q_push;
    logic           q_valid;
    logic           q_pop;
    hcdf_pkg::t_cmd push_cmd;
    hcdf_pkg::t_cmd pop_cmd;

    hcdf_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (i_cfg),
        .i_in      (i_in),
        .i_q_ready (q_ready),
        .o_q_push  (q_push),
        .o_q_cmd   (push_cmd)
    );

    hcdf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (pop_cmd)
    );

    hcdf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cmd   (pop_cmd),
        .o_q_pop   (q_pop),
        .o_out     (o_out)
    );

endmodule

[hw/rtl/hcdf_front.sv]
module hcdf_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    hcdf_cfg_if.sink         i_cfg,
    hcdf_byte_if.sink        i_in,
    input  logic             i_q_ready,
    output logic             o_q_push,
    output hcdf_pkg::t_cmd   o_q_cmd
);

    logic [31:0]               r_csum, n_csum;
    logic [31:0]               r_addr, n_addr;
    logic [hcdf_pkg::POS_W-1:0] r_pos, n_pos;
    logic                      accept;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = i_q_ready;
    assign accept      = i_in.valid && i_q_ready;
    assign o_q_push    = accept;

    always_comb begin
        o_q_cmd.data = i_in.data_byte;
        o_q_cmd.hdr  = (r_pos == '0);
        o_q_cmd.csum = r_csum[15:0];
        o_q_cmd.addr = r_addr;
    end

    always_comb begin
        n_csum = r_csum;
        n_addr = r_addr;
        n_pos  = r_pos;
        if (i_cfg.valid) begin
            n_csum = '0;
            n_addr = i_cfg.start_address;
            n_pos  = '0;
        end else if (accept) begin
            n_csum = {r_csum[30:0], r_csum[31]} ^ {24'd0, i_in.data_byte};
            n_addr = r_addr + 32'd1;
            if (r_pos == hcdf_pkg::POS_W'(hcdf_pkg::LINE_BYTES - 1)) begin
                n_pos = '0;
            end else begin
                n_pos = r_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_csum <= '0;
            r_addr <= '0;
            r_pos  <= '0;
        end else begin
            r_csum <= n_csum;
            r_addr <= n_addr;
            r_pos  <= n_pos;
        end
    end

endmodule

[hw/rtl/hcdf_queue.sv]
module hcdf_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  hcdf_pkg::t_cmd   i_cmd,
    output logic             o_ready,
    input  logic             i_pop,
    output logic             o_valid,
    output hcdf_pkg::t_cmd   o_cmd
);

    hcdf_pkg::t_cmd                r_mem [hcdf_pkg::QUEUE_DEPTH];
    logic [hcdf_pkg::QPTR_W-1:0]   r_wptr, n_wptr;
    logic [hcdf_pkg::QPTR_W-1:0]   r_rptr, n_rptr;
    logic [hcdf_pkg::QCNT_W-1:0]   r_count, n_count;

    assign o_ready = (r_count != hcdf_pkg::QCNT_W'(hcdf_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rptr];

    function automatic logic [hcdf_pkg::QPTR_W-1:0] ptr_inc(
        input logic [hcdf_pkg::QPTR_W-1:0] p
    );
        if (p == hcdf_pkg::QPTR_W'(hcdf_pkg::QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = ptr_inc(r_wptr);
        end
        if (i_pop) begin
            n_rptr = ptr_inc(r_rptr);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

endmodule

[hw/rtl/hcdf_back.sv]
module hcdf_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  hcdf_pkg::t_cmd   i_q_cmd,
    output logic             o_q_pop,
    hcdf_char_if.source      o_out
);

    logic                       r_busy;
    logic [3:0]                 r_idx;
    logic [7:0]                 r_data;
    logic [hcdf_pkg::HEX_W-1:0] r_hex;
    logic                       r_ov;
    logic [7:0]                 r_char;
    logic                       r_last;
    logic                       advance;
    logic                       at_byte;
    logic                       load;
    logic [7:0]                 n_char;
    logic                       is_digit;

    assign at_byte = (r_idx == hcdf_pkg::SLOT_BYTE);
    assign advance = r_busy && (!r_ov || o_out.ready);
    assign load    = i_q_valid && (!r_busy || (advance && at_byte));
    assign o_q_pop = load;

    assign o_out.valid       = r_ov;
    assign o_out.out_char    = r_char;
    assign o_out.last_of_run = r_last;

    always_comb begin
        is_digit = 1'b0;
        case (r_idx)
            hcdf_pkg::SLOT_SEMI:  n_char = hcdf_pkg::CH_SEMI;
            hcdf_pkg::SLOT_NL:    n_char = hcdf_pkg::CH_NL;
            hcdf_pkg::SLOT_COLON: n_char = hcdf_pkg::CH_COLON;
            hcdf_pkg::SLOT_BYTE:  n_char = r_data;
            default: begin
                n_char   = hcdf_pkg::hex_char(r_hex[hcdf_pkg::HEX_W-1 -: 4]);
                is_digit = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data <= i_q_cmd.data;
            r_hex  <= {i_q_cmd.csum, i_q_cmd.addr};
        end else if (advance && is_digit) begin
            r_hex <= {r_hex[hcdf_pkg::HEX_W-5:0], 4'd0};
        end
        if (advance) begin
            r_char <= n_char;
            r_last <= at_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= hcdf_pkg::SLOT_SEMI;
            r_ov   <= 1'b0;
        end else begin
            if (load) begin
                r_busy <= 1'b1;
                r_idx  <= i_q_cmd.hdr ? hcdf_pkg::SLOT_SEMI : hcdf_pkg::SLOT_BYTE;
            end else if (advance && at_byte) begin
                r_busy <= 1'b0;
            end else if (advance) begin
                r_idx <= r_idx + 4'd1;
            end
            if (advance) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

endmodule
